FILE: hw/rtl/spr_pkg.sv
package spr_pkg;

   localparam int NODES = 64;
   localparam int EDGES = 256;
   localparam int NODE_W = 6;
   localparam int EDGE_AW = 8;
   localparam int ECNT_W = 9;
   localparam int COST_W = 16;
   localparam int DIST_W = 23;
   localparam int LEN_W = 7;
   localparam logic [DIST_W-1:0] UNREACHED = '1;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_PICK,
      ST_RELAX,
      ST_RELAX_WR,
      ST_TRACE,
      ST_TRACE_WAIT,
      ST_EMIT,
      ST_UNREACH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_query;
      logic init_clear;
      logic init_step;
      logic scan_start;
      logic scan_step;
      logic pick;
      logic relax_start;
      logic relax_read;
      logic relax_write;
      logic trace_start;
      logic trace_step;
      logic emit_start;
      logic emit_step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic init_done;
      logic scan_done;
      logic found;
      logic relax_done;
      logic trace_done;
      logic end_unreached;
      logic bad_node;
      logic emit_last;
   } sts_type;

endpackage

FILE: hw/rtl/spr_datapath.sv
module spr_datapath
   import spr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic                edge_we,
   input  logic                edge_clr,
   input  logic [NODE_W-1:0]   req_from_node,
   input  logic [NODE_W-1:0]   req_to_node,
   input  logic [COST_W-1:0]   req_edge_cost,
   output logic [NODE_W-1:0]   rsp_route_node,
   output logic [21:0]         rsp_total_distance,
   output logic [LEN_W-1:0]    rsp_route_length,
   output logic                rsp_edge_overflow
);

   // Edge store: one write port, one registered read port.
   logic [27:0] edge_mem [EDGES];
   logic [27:0] edge_rd_ff;
   logic [ECNT_W-1:0] ecnt_ff;
   logic ovf_ff;

   // Node tables: distance and parent in memories, settled as flags.
   logic [DIST_W-1:0] dist_mem [NODES];
   logic [NODE_W-1:0] par_mem [NODES];
   logic [NODES-1:0] settled_ff;
   logic [DIST_W-1:0] dist_rd_ff;
   logic [NODE_W-1:0] par_rd_ff;

   logic [NODE_W-1:0] start_ff, end_ff;
   logic [NODE_W:0] idx_ff;
   logic [NODE_W:0] scan_rd_ff;
   logic scan_vld_ff;
   logic [NODE_W-1:0] best_ff;
   logic [DIST_W-1:0] bd_ff;
   logic found_ff;
   logic [NODE_W-1:0] cur_ff;
   logic [DIST_W-1:0] cur_d_ff;
   logic [ECNT_W-1:0] eidx_ff;
   logic [NODE_W-1:0] tnode_ff;
   logic [DIST_W-1:0] nd_ff;
   logic hit_ff;
   logic hit_now;
   logic relax_stage_ff;
   logic fin_ld_ff;
   logic trace_on_ff;
   logic [NODE_W-1:0] route_ff [NODES];
   logic [NODE_W-1:0] route_rd_ff;
   logic [LEN_W-1:0] rlen_ff;
   logic [LEN_W-1:0] rlen_m1;
   logic [LEN_W-1:0] emit_ff;
   logic [LEN_W-1:0] emit_nx;
   logic [DIST_W-1:0] fin_d_ff;
   logic trace_done_ff;

   logic [NODE_W-1:0] dist_addr;
   logic [DIST_W:0] nd_sum;

   // Edge store writes and count.
   always_ff @(posedge clock) begin
      if (edge_we && ecnt_ff < ECNT_W'(EDGES))
         edge_mem[ecnt_ff[EDGE_AW-1:0]] <= {req_from_node, req_to_node, req_edge_cost};
      if (cmd.relax_read)
         edge_rd_ff <= edge_mem[eidx_ff[EDGE_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset || edge_clr) begin
         ecnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (edge_we) begin
         if (ecnt_ff < ECNT_W'(EDGES))
            ecnt_ff <= ecnt_ff + 1'b1;
         else
            ovf_ff <= 1'b1;
      end
   end

   // Distance read address follows the active phase.
   always_comb begin
      if (cmd.relax_write || cmd.relax_read || relax_stage_ff)
         dist_addr = edge_rd_ff[21:16];
      else if (cmd.trace_start)
         dist_addr = end_ff;
      else if (trace_on_ff)
         dist_addr = cur_ff;
      else
         dist_addr = idx_ff[NODE_W-1:0];
   end

   assign nd_sum = {1'b0, cur_d_ff} + {{(DIST_W-COST_W+1){1'b0}}, edge_rd_ff[15:0]};
   assign rlen_m1 = rlen_ff - 1'b1;
   assign emit_nx = emit_ff - 1'b1;

   always_ff @(posedge clock) begin
      dist_rd_ff <= dist_mem[dist_addr];
      par_rd_ff <= par_mem[dist_addr];
      if (cmd.init_step) begin
         dist_mem[idx_ff[NODE_W-1:0]] <=
            (idx_ff[NODE_W-1:0] == start_ff) ? '0 : UNREACHED;
         par_mem[idx_ff[NODE_W-1:0]] <= start_ff;
      end else if (cmd.relax_write && hit_ff && nd_ff < dist_rd_ff) begin
         dist_mem[tnode_ff] <= nd_ff;
         par_mem[tnode_ff] <= cur_ff;
      end
   end

   // Search registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         settled_ff <= '0;
         idx_ff <= '0;
         scan_vld_ff <= 1'b0;
         found_ff <= 1'b0;
         eidx_ff <= '0;
         rlen_ff <= '0;
         emit_ff <= '0;
         trace_done_ff <= 1'b0;
         trace_on_ff <= 1'b0;
      end else begin
         scan_vld_ff <= cmd.scan_step && !idx_ff[NODE_W];
         if (cmd.load_query) begin
            start_ff <= req_from_node;
            end_ff <= req_to_node;
         end
         // Node index: cleared for a new pass, stepped by init and scan.
         if (cmd.scan_start)
            idx_ff <= '0;
         else if (cmd.load_query)
            idx_ff <= '0;
         else if (cmd.init_step || (cmd.scan_step && !idx_ff[NODE_W]))
            idx_ff <= idx_ff + 1'b1;
         if (cmd.init_clear)
            settled_ff <= '0;
         if (cmd.scan_start) begin
            found_ff <= 1'b0;
            bd_ff <= UNREACHED;
         end
         // Scan: one node read per cycle, compared in the following cycle.
         if (cmd.scan_step) begin
            if (!idx_ff[NODE_W])
               scan_rd_ff <= idx_ff;
            if (scan_vld_ff && !settled_ff[scan_rd_ff[NODE_W-1:0]]
                && dist_rd_ff < bd_ff) begin
               bd_ff <= dist_rd_ff;
               best_ff <= scan_rd_ff[NODE_W-1:0];
               found_ff <= 1'b1;
            end
         end
         if (cmd.pick) begin
            settled_ff[best_ff] <= 1'b1;
            cur_ff <= best_ff;
            cur_d_ff <= bd_ff;
         end
         if (cmd.relax_start)
            eidx_ff <= '0;
         if (cmd.relax_read)
            eidx_ff <= eidx_ff + 1'b1;
         // Trace phase steers the node tables to the current route node.
         if (cmd.trace_start)
            trace_on_ff <= 1'b1;
         else if (cmd.emit_start || cmd.load_query)
            trace_on_ff <= 1'b0;
         if (cmd.trace_start) begin
            cur_ff <= end_ff;
            rlen_ff <= '0;
            trace_done_ff <= 1'b0;
         end
         if (cmd.trace_step) begin
            route_ff[rlen_ff[NODE_W-1:0]] <= cur_ff;
            rlen_ff <= rlen_ff + 1'b1;
            if (cur_ff == start_ff || rlen_ff == LEN_W'(NODES - 1))
               trace_done_ff <= 1'b1;
            else
               cur_ff <= par_rd_ff;
         end
         // Route read is registered; the next node is fetched as a beat leaves.
         if (cmd.emit_start) begin
            emit_ff <= rlen_m1;
            route_rd_ff <= route_ff[rlen_m1[NODE_W-1:0]];
         end
         if (cmd.emit_step) begin
            emit_ff <= emit_nx;
            route_rd_ff <= route_ff[emit_nx[NODE_W-1:0]];
         end
      end
   end

   assign hit_now = edge_rd_ff[27:22] == cur_ff;

   // Relaxation pipeline: the edge word lands, then the target distance.
   always_ff @(posedge clock) begin
      if (reset) begin
         relax_stage_ff <= 1'b0;
         fin_ld_ff <= 1'b0;
      end else begin
         relax_stage_ff <= cmd.relax_read;
         fin_ld_ff <= cmd.trace_start;
      end
      if (relax_stage_ff) begin
         tnode_ff <= edge_rd_ff[21:16];
         nd_ff <= nd_sum[DIST_W] ? UNREACHED : nd_sum[DIST_W-1:0];
         hit_ff <= hit_now;
      end
      // The end node distance, read from the table as the trace starts, is held in fin_d_ff.
      if (fin_ld_ff)
         fin_d_ff <= dist_rd_ff;
   end

   assign sts.init_done = idx_ff == (NODE_W+1)'(NODES - 1);
   assign sts.scan_done = idx_ff[NODE_W] && !scan_vld_ff;
   assign sts.found = found_ff;
   assign sts.relax_done = eidx_ff >= ecnt_ff;
   assign sts.trace_done = trace_done_ff;
   assign sts.end_unreached = dist_rd_ff == UNREACHED;
   assign sts.bad_node = 1'b0;
   assign sts.emit_last = emit_ff == '0;

   assign rsp_route_node = route_rd_ff;
   assign rsp_total_distance = fin_d_ff[21:0];
   assign rsp_route_length = rlen_ff;
   assign rsp_edge_overflow = ovf_ff;

endmodule

FILE: hw/rtl/spr_ctrl.sv
module spr_ctrl
   import spr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  logic [1:0] req_opcode,
   input  logic      rsp_ready,
   output logic      rsp_valid,
   output logic      rsp_unreach,
   output logic      rsp_last,
   output logic      edge_we,
   output logic      edge_clr,
   output cmd_type   cmd,
   input  sts_type   sts
);

   state_type state_ff, state_in;
   logic [1:0] wait_ff, wait_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff <= wait_in;
      end
   end

   // Next state and commands.
   always_comb begin
      logic acc;
      acc = 1'b0;
      state_in = state_ff;
      wait_in = wait_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rsp_unreach = 1'b0;
      rsp_last = 1'b0;
      edge_we = 1'b0;
      edge_clr = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            acc = req_valid;
            if (acc) begin
               case (req_opcode)
                  OP_LOAD: edge_we = 1'b1;
                  OP_CLEAR: edge_clr = 1'b1;
                  OP_QUERY: begin
                     cmd.load_query = 1'b1;
                     state_in = ST_INIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_INIT: begin
            cmd.init_step = 1'b1;
            cmd.init_clear = 1'b1;
            if (sts.init_done) begin
               cmd.scan_start = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = ST_PICK;
         end
         ST_PICK: begin
            if (sts.found) begin
               cmd.pick = 1'b1;
               cmd.relax_start = 1'b1;
               state_in = ST_RELAX;
            end else begin
               cmd.trace_start = 1'b1;
               wait_in = 2'd0;
               state_in = ST_TRACE_WAIT;
            end
         end
         ST_RELAX: begin
            if (sts.relax_done) begin
               cmd.scan_start = 1'b1;
               state_in = ST_SCAN;
            end else begin
               cmd.relax_read = 1'b1;
               wait_in = 2'd0;
               state_in = ST_RELAX_WR;
            end
         end
         ST_RELAX_WR: begin
            wait_in = wait_ff + 1'b1;
            if (wait_ff == 2'd1) begin
               cmd.relax_write = 1'b1;
               state_in = ST_RELAX;
            end
         end
         ST_TRACE_WAIT: begin
            if (sts.end_unreached) state_in = ST_UNREACH;
            else state_in = ST_TRACE;
         end
         ST_TRACE: begin
            if (sts.trace_done) begin
               cmd.emit_start = 1'b1;
               state_in = ST_EMIT;
            end else begin
               cmd.trace_step = 1'b1;
               state_in = ST_TRACE_WAIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            rsp_last = sts.emit_last;
            if (rsp_ready) begin
               cmd.emit_step = 1'b1;
               if (sts.emit_last) state_in = ST_IDLE;
            end
         end
         ST_UNREACH: begin
            rsp_valid = 1'b1;
            rsp_unreach = 1'b1;
            rsp_last = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: hw/rtl/shortest_path_with_route_top.sv
// Edge load and clear beats are taken without leaving the idle state.
// A query scans every node for each settled node and reads each stored edge
// through the one store read port, then traces the route back from the end node.
// One query runs at a time; input waits until its last result beat is taken.
// Reset (synchronous, active high) empties the edge store and clears overflow.
module shortest_path_with_route_top
   import spr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [5:0]  req_from_node,
   input  logic [5:0]  req_to_node,
   input  logic [15:0] req_edge_cost,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_route_node,
   output logic [21:0] rsp_total_distance,
   output logic [6:0]  rsp_route_length,
   output logic        rsp_unreachable,
   output logic        rsp_edge_overflow,
   output logic        rsp_last
);

   cmd_type cmd;
   sts_type sts;
   logic edge_we, edge_clr, unr;
   logic [5:0] node_dp, end_q;
   logic [21:0] dist_dp;
   logic [6:0] len_dp;

   spr_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_opcode, .rsp_ready, .rsp_valid,
      .rsp_unreach(unr), .rsp_last, .edge_we, .edge_clr, .cmd, .sts
   );

   spr_datapath u_dp (
      .clock, .reset, .cmd, .sts, .edge_we, .edge_clr, .req_from_node, .req_to_node,
      .req_edge_cost, .rsp_route_node(node_dp), .rsp_total_distance(dist_dp),
      .rsp_route_length(len_dp), .rsp_edge_overflow
   );

   // Query end node kept for the unreachable beat.
   always_ff @(posedge clock) begin
      if (cmd.load_query) end_q <= req_to_node;
   end

   assign rsp_unreachable = unr;
   assign rsp_route_node = unr ? end_q : node_dp;
   assign rsp_total_distance = unr ? '0 : dist_dp;
   assign rsp_route_length = unr ? 7'd1 : len_dp;

endmodule

FILE: sim/route_checker.sv
// Watches both channels of the shortest path block, predicts the route beats
// for every accepted query and compares each result beat in order.
module route_checker
   import spr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [5:0]  req_from_node,
   input  logic [5:0]  req_to_node,
   input  logic [15:0] req_edge_cost,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [5:0]  rsp_route_node,
   input  logic [21:0] rsp_total_distance,
   input  logic [6:0]  rsp_route_length,
   input  logic        rsp_unreachable,
   input  logic        rsp_edge_overflow,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending,
   output int          beats_checked,
   output int          queries_seen
);

   typedef struct {
      logic [5:0]  node;
      logic [21:0] total;
      logic [6:0]  len;
      logic        unr;
      logic        ovf;
      logic        last;
   } route_beat_type;

   route_beat_type route_q[$];

   // Shadow copy of the graph held by the block.
   logic [5:0]  edge_src[EDGES];
   logic [5:0]  edge_dst[EDGES];
   logic [15:0] edge_wt[EDGES];
   int          num_edges;
   logic        dropped_edge;

   // Search results for the current query.
   logic [DIST_W-1:0] dist_of[NODES];
   logic [5:0]        parent_of[NODES];
   bit                settled_of[NODES];

   initial begin
      fail_count = 0;
      beats_checked = 0;
      queries_seen = 0;
      num_edges = 0;
      dropped_edge = 1'b0;
   end

   assign pending = route_q.size();

   task automatic report(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // Settles nodes by smallest (distance, index) and relaxes edges in load order.
   function automatic void find_distances(input logic [5:0] start);
      int best;
      int cand;
      logic [DIST_W-1:0] best_dist;
      for (int i = 0; i < NODES; i++) begin
         dist_of[i] = UNREACHED;
         parent_of[i] = '0;
         settled_of[i] = 1'b0;
      end
      dist_of[start] = '0;
      parent_of[start] = start;
      while (1) begin
         best = -1;
         best_dist = UNREACHED;
         for (int i = 0; i < NODES; i++) begin
            if (!settled_of[i] && dist_of[i] < best_dist) begin
               best_dist = dist_of[i];
               best = i;
            end
         end
         if (best < 0) break;
         settled_of[best] = 1'b1;
         for (int e = 0; e < num_edges; e++) begin
            if (edge_src[e] == best) begin
               cand = int'(best_dist) + int'(edge_wt[e]);
               if (cand > int'(UNREACHED)) cand = int'(UNREACHED);
               if (cand < int'(dist_of[edge_dst[e]])) begin
                  dist_of[edge_dst[e]] = cand[DIST_W-1:0];
                  parent_of[edge_dst[e]] = best[5:0];
               end
            end
         end
      end
   endfunction

   // Queues the route beats of one query, start node first.
   function automatic void predict_route(input logic [5:0] start, input logic [5:0] goal);
      logic [5:0] path[$];
      logic [5:0] cur;
      route_beat_type b;
      find_distances(start);
      if (dist_of[goal] == UNREACHED) begin
         b = '{goal, 22'd0, 7'd1, 1'b1, dropped_edge, 1'b1};
         route_q = {route_q, b};
         return;
      end
      cur = goal;
      while (path.size() < NODES) begin
         path.push_front(cur);
         if (cur == start) break;
         cur = parent_of[cur];
      end
      for (int k = 0; k < path.size(); k++) begin
         b.node = path[k];
         b.total = dist_of[goal][21:0];
         b.len = 7'(path.size());
         b.unr = 1'b0;
         b.ovf = dropped_edge;
         b.last = (k == path.size() - 1);
         route_q = {route_q, b};
      end
   endfunction

   // Input beats update the shadow graph or start a prediction.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         case (req_opcode)
            OP_LOAD: begin
               if (num_edges < EDGES) begin
                  edge_src[num_edges] = req_from_node;
                  edge_dst[num_edges] = req_to_node;
                  edge_wt[num_edges] = req_edge_cost;
                  num_edges++;
               end else begin
                  dropped_edge = 1'b1;
               end
            end
            OP_CLEAR: begin
               num_edges = 0;
               dropped_edge = 1'b0;
            end
            OP_QUERY: begin
               queries_seen++;
               predict_route(req_from_node, req_to_node);
            end
            default: ;
         endcase
      end
   end

   // Result beats are compared with the oldest expectation.
   always @(posedge clock) begin
      route_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (route_q.size() == 0) begin
            report("queued expectations", 0, 1);
         end else begin
            want = route_q.pop_front();
            beats_checked++;
            if (rsp_route_node !== want.node)
               report("route_node", rsp_route_node, want.node);
            if (rsp_total_distance !== want.total)
               report("total_distance", rsp_total_distance, want.total);
            if (rsp_route_length !== want.len)
               report("route_length", rsp_route_length, want.len);
            if (rsp_unreachable !== want.unr)
               report("unreachable", rsp_unreachable, want.unr);
            if (rsp_edge_overflow !== want.ovf)
               report("edge_overflow", rsp_edge_overflow, want.ovf);
            if (rsp_last !== want.last)
               report("last", rsp_last, want.last);
         end
      end
   end

endmodule

FILE: sim/tb.sv
module tb;
   import spr_pkg::*;

   // Opcode that the block ignores.
   localparam logic [1:0] OP_NONE = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = OP_CLEAR;
   logic [5:0]  req_from_node = '0;
   logic [5:0]  req_to_node = '0;
   logic [15:0] req_edge_cost = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_route_node;
   logic [21:0] rsp_total_distance;
   logic [6:0]  rsp_route_length;
   logic        rsp_unreachable;
   logic        rsp_edge_overflow;
   logic        rsp_last;

   int fail_count;
   int pending;
   int beats_checked;
   int queries_seen;
   int items_sent = 0;
   bit calm = 1'b0;
   bit hold_req = 1'b0;
   bit hold_taken = 1'b0;

   shortest_path_with_route_top i_dut (.*);

   route_checker i_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Generous bound: the slowest phase is the 64-node chain query.
   initial begin
      #20000000;
      $display("FAIL shortest_path_with_route_top");
      $finish;
   end

   // Receiver: random stalls, a calm stretch, and one long hold-off once
   // results of the requested query start to appear.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req && !hold_taken && rsp_valid) begin
            hold_taken = 1'b1;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 31);
         end
      end
   end

   // Offers one beat and waits for it to be taken, then maybe idles.
   task automatic send_beat(input logic [1:0] op, input logic [5:0] src,
                            input logic [5:0] dst, input logic [15:0] wt);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_from_node <= src;
      req_to_node <= dst;
      req_edge_cost <= wt;
      do @(posedge clock); while (!(req_valid && req_ready));
      if (op != OP_NONE) items_sent++;
      if (!calm && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic random_phase();
      logic [5:0] pool[8];
      int n_edges;
      int n_queries;
      foreach (pool[i]) pool[i] = 6'($urandom_range(63));
      send_beat(OP_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));
      n_edges = $urandom_range(4, 18);
      for (int i = 0; i < n_edges; i++) begin
         // Mostly small weights so that ties and alternative routes occur.
         send_beat(OP_LOAD, pool[$urandom_range(7)], pool[$urandom_range(7)],
                   ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8)));
         if ($urandom_range(19) == 0)
            send_beat(OP_NONE, 6'($urandom), 6'($urandom), 16'($urandom));
      end
      n_queries = $urandom_range(2, 5);
      for (int i = 0; i < n_queries; i++) begin
         if ($urandom_range(9) == 0)
            send_beat(OP_QUERY, pool[$urandom_range(7)], 6'($urandom), 16'($urandom));
         else
            send_beat(OP_QUERY, pool[$urandom_range(7)], pool[$urandom_range(7)],
                      16'($urandom));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: equal-cost tie, zero cost, extreme weights and node numbers.
      send_beat(OP_LOAD, 6'd0, 6'd1, 16'hFFFF);
      send_beat(OP_LOAD, 6'd1, 6'd2, 16'd0);
      send_beat(OP_LOAD, 6'd0, 6'd2, 16'hFFFF);
      send_beat(OP_LOAD, 6'd2, 6'd63, 16'd1);
      send_beat(OP_LOAD, 6'd63, 6'd63, 16'd5);
      send_beat(OP_NONE, 6'd0, 6'd5, 16'd1);
      send_beat(OP_QUERY, 6'd0, 6'd2, 16'd0);
      send_beat(OP_QUERY, 6'd0, 6'd63, 16'd0);
      send_beat(OP_QUERY, 6'd0, 6'd0, 16'd0);
      send_beat(OP_QUERY, 6'd0, 6'd5, 16'd0);
      send_beat(OP_QUERY, 6'd63, 6'd0, 16'd0);
      send_beat(OP_CLEAR, 6'd0, 6'd0, 16'd0);
      send_beat(OP_QUERY, 6'd0, 6'd1, 16'd0);

      // Random graphs: the first without any idling.
      calm = 1'b1;
      random_phase();
      calm = 1'b0;
      while (items_sent < 80) random_phase();

      // Full edge store: a 64-node chain at top weight, then filler edges,
      // then one more edge that is dropped and flagged.
      send_beat(OP_CLEAR, 6'd0, 6'd0, 16'd0);
      for (int i = 0; i < NODES - 1; i++)
         send_beat(OP_LOAD, 6'(i), 6'(i + 1), 16'hFFFF);
      for (int i = NODES - 1; i <= EDGES; i++)
         send_beat(OP_LOAD, 6'd63, 6'd62, 16'($urandom));

      // Longest route while the receiver holds off.
      hold_req = 1'b1;
      send_beat(OP_QUERY, 6'd0, 6'd63, 16'd0);
      for (int i = 0; i < 4; i++)
         send_beat(OP_QUERY, 6'(60 + i), 6'd63, 16'd0);
      send_beat(OP_QUERY, 6'd63, 6'd62, 16'd0);
      send_beat(OP_CLEAR, 6'd0, 6'd0, 16'd0);
      send_beat(OP_QUERY, 6'd63, 6'd62, 16'd0);
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Ran %0d queries over directed, random, full-store and chain graphs;",
               queries_seen);
      $display("%0d route beats compared.", beats_checked);
      if (fail_count == 0 && pending == 0)
         $display("PASS shortest_path_with_route_top");
      else
         $display("FAIL shortest_path_with_route_top");
      $finish;
   end

endmodule

FILE: shortest_path_with_route_top.f
hw/rtl/spr_pkg.sv
hw/rtl/spr_datapath.sv
hw/rtl/spr_ctrl.sv
hw/rtl/shortest_path_with_route_top.sv
sim/route_checker.sv
sim/tb.sv
